/* design/atfb_pkg.sv */
// Package for the ATA task-file builder: request and result types,
// addressing mode codes and ATA opcodes.
// No dependencies.
`default_nettype none

package atfb_pkg;

  // Addressing mode reported with each result
  typedef enum logic [1:0] {
    MODE_CHS   = 2'd0,
    MODE_LBA28 = 2'd1,
    MODE_LBA48 = 2'd2
  } mode_t;

  // ATA command opcodes
  localparam logic [7:0] OP_READ_PIO      = 8'h20;
  localparam logic [7:0] OP_READ_PIO_EXT  = 8'h24;
  localparam logic [7:0] OP_WRITE_PIO     = 8'h30;
  localparam logic [7:0] OP_WRITE_PIO_EXT = 8'h34;
  localparam logic [7:0] OP_FLUSH         = 8'hE7;
  localparam logic [7:0] OP_FLUSH_EXT     = 8'hEA;
  localparam logic [7:0] OP_NONE          = 8'h00;

  // Device select base values
  localparam logic [7:0] DEV_BASE_CHS = 8'hA0;
  localparam logic [7:0] DEV_BASE_LBA = 8'hE0;

  // Request fields that ride along the divider pipeline
  typedef struct packed {
    logic [31:0] addr;
    logic        wr;
    logic        slave;
    logic        cap;
    logic [7:0]  sectors;
  } req_t;

  // Request plus sector index within the track
  typedef struct packed {
    req_t       req;
    logic [7:0] sec_rem;
  } trk_t;

  // Task-file result
  typedef struct packed {
    mode_t      mode;
    logic [7:0] dev_sel;
    logic [7:0] cnt_lo;
    logic [7:0] cnt_hi;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] cmd;
    logic [7:0] flush;
  } res_t;

endpackage

`default_nettype wire

/* design/atfb_cdiv.sv */
// Three-stage divider by a constant: reciprocal multiply, back-multiply,
// one-step correction. Carries a side word along with each item.
// Depends on nothing but its parameters.
`default_nettype none

module atfb_cdiv #(
  parameter int WIDTH   = 28,
  parameter int DIVISOR = 63,
  parameter int SIDE_W  = 8,
  localparam int REM_W  = $clog2(DIVISOR + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WIDTH-1:0]  in_x,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WIDTH-1:0]       out_q,
  output logic [REM_W-1:0]       out_rem,
  output logic [SIDE_W-1:0]      out_side
);

  // Reciprocal: estimate is exact or one low for any WIDTH-bit dividend
  localparam int SHIFT = WIDTH + 3;
  localparam int PW    = WIDTH + SHIFT + 1;
  localparam logic [SHIFT:0] MULT = (SHIFT + 1)'((64'd1 << SHIFT) / DIVISOR);
  localparam logic [REM_W-1:0] DIV_C = REM_W'(DIVISOR);

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  logic [PW-1:0]     prod1;
  logic [REM_W:0]    xl1, xl2;
  logic [SIDE_W-1:0] side1, side2;
  logic [WIDTH-1:0]  qe2;
  logic [REM_W:0]    qd2;
  logic [WIDTH-1:0]  qe_next;
  logic [2*REM_W+1:0] qd_full;
  logic [REM_W:0]    rem_e;

  // Stall chain: a stage loads when it is empty or its successor loads
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: reciprocal product
  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod1 <= PW'(in_x) * PW'(MULT);
      xl1   <= in_x[REM_W:0];
      side1 <= in_side;
    end
  end

  // Stage 2: quotient estimate and its back-product (low bits suffice)
  assign qe_next = prod1[SHIFT +: WIDTH];
  assign qd_full = (2*REM_W+2)'(qe_next[REM_W:0]) * (2*REM_W+2)'(DIV_C);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      qe2   <= qe_next;
      qd2   <= qd_full[REM_W:0];
      xl2   <= xl1;
      side2 <= side1;
    end
  end

  // Stage 3: remainder lies in [0, 2*DIVISOR), fix up once
  assign rem_e = xl2 - qd2;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_side <= side2;
      if (rem_e >= {1'b0, DIV_C}) begin
        out_q   <= qe2 + WIDTH'(1);
        out_rem <= REM_W'(rem_e - {1'b0, DIV_C});
      end else begin
        out_q   <= qe2;
        out_rem <= REM_W'(rem_e);
      end
    end
  end

endmodule

`default_nettype wire

/* design/atfb_fmt.sv */
// Output stage: picks the addressing mode and builds the task-file bytes
// into the result register. Uses atfb_pkg types and opcodes.
`default_nettype none

module atfb_fmt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire atfb_pkg::trk_t in_trk,
  input  wire logic [15:0]    in_cyl,
  input  wire logic [3:0]     in_head,
  output logic                out_valid,
  input  wire logic           out_ready,
  output atfb_pkg::res_t      out_res
);

  atfb_pkg::res_t res_next;
  atfb_pkg::req_t req;
  logic           big;
  logic [7:0]     base;
  logic [3:0]     head;

  assign in_ready = !out_valid || out_ready;
  assign req      = in_trk.req;
  assign big      = (req.addr[31:28] != 4'd0);

  // Field assembly
  always_comb begin
    res_next        = '0;
    res_next.cnt_lo = req.sectors;
    base            = atfb_pkg::DEV_BASE_LBA;
    head            = 4'd0;
    res_next.b0     = req.addr[7:0];
    res_next.b1     = req.addr[15:8];
    res_next.b2     = req.addr[23:16];
    if (big) begin
      res_next.mode = atfb_pkg::MODE_LBA48;
      res_next.b3   = req.addr[31:24];
    end else if (req.cap) begin
      res_next.mode = atfb_pkg::MODE_LBA28;
      head          = req.addr[27:24];
    end else begin
      res_next.mode = atfb_pkg::MODE_CHS;
      base          = atfb_pkg::DEV_BASE_CHS;
      head          = in_head;
      res_next.b0   = in_trk.sec_rem + 8'd1;
      res_next.b1   = in_cyl[7:0];
      res_next.b2   = in_cyl[15:8];
    end
    res_next.dev_sel = base | {3'd0, req.slave, head};
    // Command and flush opcodes
    if (req.wr) begin
      res_next.cmd   = big ? atfb_pkg::OP_WRITE_PIO_EXT : atfb_pkg::OP_WRITE_PIO;
      res_next.flush = big ? atfb_pkg::OP_FLUSH_EXT : atfb_pkg::OP_FLUSH;
    end else begin
      res_next.cmd   = big ? atfb_pkg::OP_READ_PIO_EXT : atfb_pkg::OP_READ_PIO;
      res_next.flush = atfb_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_res <= res_next;
  end

endmodule

`default_nettype wire

/* design/ata_task_file_builder_unit.sv */
// ATA task-file builder, top level: request decode, CHS divider chain and
// output stage. Depends on atfb_pkg, atfb_cdiv and atfb_fmt.
// Two 3-stage constant dividers (sectors per track, then heads) feed the
// output register. Throughput: one item per cycle while the output is not
// stalled; stalls back up stage by stage.
// Reset (rst, synchronous) clears all valid bits; no other state.
`default_nettype none

module ata_task_file_builder_unit #(
  parameter int SECTORS_PER_TRACK  = 63,
  parameter int HEADS_PER_CYLINDER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] block_address, [32] direction, [33] drive_is_slave,
  // [34] lba_capable, [51:35] xfer_bytes, [55:52] zero
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] address_mode, [9:2] device_select, [17:10] sector_count_low,
  // [25:18] sector_count_high, [33:26] addr_byte0, [41:34] addr_byte1,
  // [49:42] addr_byte2, [57:50] addr_byte3, [65:58] addr_byte4,
  // [73:66] addr_byte5, [81:74] command_code, [89:82] flush_code, [95:90] zero
  output logic [95:0]      m_tdata
);

  localparam int AW     = 28;
  localparam int REQ_W  = $bits(atfb_pkg::req_t);
  localparam int TRK_W  = $bits(atfb_pkg::trk_t);
  localparam int SREM_W = $clog2(SECTORS_PER_TRACK + 1);
  localparam int HREM_W = $clog2(HEADS_PER_CYLINDER + 1);

  atfb_pkg::req_t     req_in;
  atfb_pkg::trk_t     trk1, trk2;
  atfb_pkg::res_t     res;
  logic [17:0]        byte_sum;
  logic               d1_valid, d1_ready;
  logic [AW-1:0]      track;
  logic [SREM_W-1:0]  sec_rem;
  logic [REQ_W-1:0]   d1_side;
  logic               d2_valid, d2_ready;
  logic [AW-1:0]      cyl_full;
  logic [HREM_W-1:0]  head_rem;
  logic [TRK_W-1:0]   d2_side;

  // Request decode: sector count rounds up to whole 512-byte sectors
  assign byte_sum       = 18'(s_tdata[51:35]) + 18'd511;
  assign req_in.addr    = s_tdata[31:0];
  assign req_in.wr      = s_tdata[32];
  assign req_in.slave   = s_tdata[33];
  assign req_in.cap     = s_tdata[34];
  assign req_in.sectors = byte_sum[16:9];

  // Block address into track number and sector within track
  atfb_cdiv #(
    .WIDTH   (AW),
    .DIVISOR (SECTORS_PER_TRACK),
    .SIDE_W  (REQ_W)
  ) u_div_spt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[AW-1:0]),
    .in_side   (req_in),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .out_q     (track),
    .out_rem   (sec_rem),
    .out_side  (d1_side)
  );

  assign trk1.req     = atfb_pkg::req_t'(d1_side);
  assign trk1.sec_rem = 8'(sec_rem);

  // Track number into cylinder and head
  atfb_cdiv #(
    .WIDTH   (AW),
    .DIVISOR (HEADS_PER_CYLINDER),
    .SIDE_W  (TRK_W)
  ) u_div_hpc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_ready  (d1_ready),
    .in_x      (track),
    .in_side   (trk1),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .out_q     (cyl_full),
    .out_rem   (head_rem),
    .out_side  (d2_side)
  );

  assign trk2 = atfb_pkg::trk_t'(d2_side);

  // Task-file assembly and output register
  atfb_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .in_ready  (d2_ready),
    .in_trk    (trk2),
    .in_cyl    (16'(cyl_full)),
    .in_head   (4'(head_rem)),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {6'd0, res.flush, res.cmd, res.b5, res.b4, res.b3, res.b2,
                    res.b1, res.b0, res.cnt_hi, res.cnt_lo, res.dev_sel,
                    res.mode};

  // Input only stalls when the whole pipeline is full, result included
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  // CHS sector numbers are one-based
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.mode == atfb_pkg::MODE_CHS) |-> (res.b0 != 8'd0))
    else $error("CHS sector number zero");

  // Reads never carry a flush opcode
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.cmd == atfb_pkg::OP_READ_PIO ||
                  res.cmd == atfb_pkg::OP_READ_PIO_EXT))
      |-> (res.flush == atfb_pkg::OP_NONE))
    else $error("flush opcode on a read");

endmodule

`default_nettype wire

/* bench/atfb_task_file_checker.sv */
// Checker for the ATA task-file builder: watches both streams, predicts
// each task file from the accepted request and compares the results.
// Depends on atfb_pkg for the mode codes, opcodes and result struct.
`timescale 1ns / 100ps

module atfb_task_file_checker #(
  parameter int SECTORS_PER_TRACK  = 63,
  parameter int HEADS_PER_CYLINDER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  // [31:0] block_address, [32] direction, [33] drive_is_slave,
  // [34] lba_capable, [51:35] xfer_bytes, [55:52] zero
  input  wire logic [55:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // [1:0] address_mode, [9:2] device_select, [17:10] sector_count_low,
  // [25:18] sector_count_high, [33:26] addr_byte0 .. [73:66] addr_byte5,
  // [81:74] command_code, [89:82] flush_code, [95:90] zero
  input  wire logic [95:0] m_tdata,
  output int unsigned      fail_count,
  output int unsigned      pending_count
);

  localparam logic [31:0] LBA48_START = 32'h1000_0000;

  atfb_pkg::res_t expected_task_files[$];
  int unsigned    mismatches = 0;
  int unsigned    queued     = 0;

  assign fail_count    = mismatches;
  assign pending_count = queued;

  // Task file that one request should produce
  function automatic atfb_pkg::res_t build_task_file(logic [55:0] req);
    logic [31:0]    addr;
    logic           wr;
    logic           slave;
    logic           cap;
    logic [31:0]    sectors;
    logic [31:0]    sec_in_track;
    logic [31:0]    track_base;
    logic [31:0]    cyl;
    logic [31:0]    head;
    logic           ext;
    atfb_pkg::res_t tf;
    addr    = req[31:0];
    wr      = req[32];
    slave   = req[33];
    cap     = req[34];
    sectors = ({15'd0, req[51:35]} + 32'd511) / 32'd512;
    tf        = '0;
    tf.cnt_lo = sectors[7:0];
    ext       = (addr >= LBA48_START);
    if (ext) begin
      tf.mode    = atfb_pkg::MODE_LBA48;
      tf.dev_sel = atfb_pkg::DEV_BASE_LBA | {3'b000, slave, 4'h0};
      tf.b0      = addr[7:0];
      tf.b1      = addr[15:8];
      tf.b2      = addr[23:16];
      tf.b3      = addr[31:24];
    end else if (cap) begin
      tf.mode    = atfb_pkg::MODE_LBA28;
      tf.dev_sel = atfb_pkg::DEV_BASE_LBA | {3'b000, slave, addr[27:24]};
      tf.b0      = addr[7:0];
      tf.b1      = addr[15:8];
      tf.b2      = addr[23:16];
    end else begin
      // CHS geometry; the cylinder wraps at 16 bits
      sec_in_track = addr % SECTORS_PER_TRACK;
      track_base   = addr - sec_in_track;
      cyl          = track_base / (SECTORS_PER_TRACK * HEADS_PER_CYLINDER);
      head         = (track_base % (SECTORS_PER_TRACK * HEADS_PER_CYLINDER))
                     / SECTORS_PER_TRACK;
      tf.mode    = atfb_pkg::MODE_CHS;
      tf.dev_sel = atfb_pkg::DEV_BASE_CHS | {3'b000, slave, head[3:0]};
      tf.b0      = sec_in_track[7:0] + 8'd1;
      tf.b1      = cyl[7:0];
      tf.b2      = cyl[15:8];
    end
    if (wr) begin
      tf.cmd   = ext ? atfb_pkg::OP_WRITE_PIO_EXT : atfb_pkg::OP_WRITE_PIO;
      tf.flush = ext ? atfb_pkg::OP_FLUSH_EXT : atfb_pkg::OP_FLUSH;
    end else begin
      tf.cmd   = ext ? atfb_pkg::OP_READ_PIO_EXT : atfb_pkg::OP_READ_PIO;
      tf.flush = atfb_pkg::OP_NONE;
    end
    return tf;
  endfunction

  task automatic check_byte(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result item with the oldest prediction, then queue new ones
  always @(posedge clk) begin
    atfb_pkg::res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_task_files.size() == 0) begin
          $error("result item 0x%024h arrived with no request pending", m_tdata);
          mismatches++;
        end else begin
          want = expected_task_files.pop_front();
          check_byte("address_mode", {6'd0, want.mode}, {6'd0, m_tdata[1:0]});
          check_byte("device_select", want.dev_sel, m_tdata[9:2]);
          check_byte("sector_count_low", want.cnt_lo, m_tdata[17:10]);
          check_byte("sector_count_high", want.cnt_hi, m_tdata[25:18]);
          check_byte("addr_byte0", want.b0, m_tdata[33:26]);
          check_byte("addr_byte1", want.b1, m_tdata[41:34]);
          check_byte("addr_byte2", want.b2, m_tdata[49:42]);
          check_byte("addr_byte3", want.b3, m_tdata[57:50]);
          check_byte("addr_byte4", want.b4, m_tdata[65:58]);
          check_byte("addr_byte5", want.b5, m_tdata[73:66]);
          check_byte("command_code", want.cmd, m_tdata[81:74]);
          check_byte("flush_code", want.flush, m_tdata[89:82]);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_task_files.push_back(build_task_file(s_tdata));
      end
    end
    queued <= expected_task_files.size();
  end

endmodule

/* bench/ata_task_file_builder_unit_tb.sv */
// Testbench top for ata_task_file_builder_unit: drives request items in
// bursts, stalls the result side and reports the verdict.
// Depends on atfb_pkg, the block and atfb_task_file_checker.
`timescale 1ns / 100ps

module ata_task_file_builder_unit_tb;

  localparam int SPT          = 63;
  localparam int HEADS        = 16;
  localparam int CYL_SECTORS  = SPT * HEADS;
  localparam int RANDOM_ITEMS = 1650;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending_count;

  // Handshake between request source and result sink for the long hold-off
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  // Coverage tallies for the summary
  int unsigned chs_sent   = 0;
  int unsigned lba28_sent = 0;
  int unsigned lba48_sent = 0;
  int unsigned writes     = 0;
  int unsigned cycle_count = 0;

  ata_task_file_builder_unit #(
    .SECTORS_PER_TRACK (SPT),
    .HEADS_PER_CYLINDER(HEADS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  atfb_task_file_checker #(
    .SECTORS_PER_TRACK (SPT),
    .HEADS_PER_CYLINDER(HEADS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one request item and hold it until the block takes it
  task automatic send_request(logic [31:0] addr, logic wr, logic slave, logic cap,
                              logic [16:0] bytes);
    s_tdata  <= {4'h0, bytes, cap, slave, wr, addr};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (addr >= 32'h1000_0000) lba48_sent++;
    else if (cap) lba28_sent++;
    else chs_sent++;
    if (wr) writes++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Result sink: m_tready is random, with a ready percentage that is redrawn periodically
  initial begin : result_sink
    int unsigned pattern_left;
    int unsigned ready_pct;
    pattern_left = 0;
    ready_pct    = 100;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long hold-off so the pipeline fills and backs up into the input
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 50;
            default: ready_pct = 20;
          endcase
        end
        pattern_left--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_count);
    $display("ata_task_file_builder_unit_tb: FAIL");
    $finish;
  end

  initial begin : request_source
    logic [31:0] addr;
    logic        cap;
    logic [16:0] bytes;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned cyl;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: track and cylinder edges, count wrap, mode thresholds
    send_request(32'h0000_0000, 1'b0, 1'b0, 1'b0, 17'd0);
    send_request(32'h0000_0000, 1'b1, 1'b1, 1'b1, 17'd1);
    send_request(32'd62, 1'b0, 1'b0, 1'b0, 17'd511);
    send_request(32'd63, 1'b1, 1'b0, 1'b0, 17'd512);
    send_request(CYL_SECTORS - 1, 1'b0, 1'b1, 1'b0, 17'd513);
    send_request(CYL_SECTORS, 1'b1, 1'b1, 1'b0, 17'd1024);
    send_request(65535 * CYL_SECTORS, 1'b0, 1'b0, 1'b0, 17'd4096);
    // cylinder past 16 bits wraps
    send_request(65536 * CYL_SECTORS, 1'b1, 1'b0, 1'b0, 17'd130560);
    send_request(32'h0FFF_FFFF, 1'b1, 1'b1, 1'b0, 17'd131071);
    send_request(32'h0FFF_FFFF, 1'b0, 1'b1, 1'b1, 17'd130560);
    send_request(32'h0F00_0000, 1'b1, 1'b0, 1'b1, 17'd130561);
    // LBA48 regardless of capability bit
    send_request(32'h1000_0000, 1'b0, 1'b0, 1'b0, 17'd130561);
    send_request(32'h1000_0000, 1'b1, 1'b1, 1'b1, 17'd512);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 17'd131071);
    send_request(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 17'd0);
    send_request(32'hA5A5_A5A5, 1'b0, 1'b1, 1'b1, 17'h15A5A);
    send_request(32'h05A5_A5A5, 1'b1, 1'b0, 1'b1, 17'h0A5A5);
    send_request(32'h05A5_A5A5, 1'b0, 1'b1, 1'b0, 17'h1FFFF);
    send_request(32'h0A5A_5A5A, 1'b1, 1'b0, 1'b0, 17'd256);
    send_request(32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0, 17'd1);
    drain_results();

    // Random part; the sink holds off for a long stretch at its start
    hold_off_req = 1'b1;
    burst_left   = $urandom_range(1, 32);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      cap = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: addr = $urandom();
        1, 2: begin
          addr = $urandom_range(0, 32'h0FFF_FFFF);
          cap  = 1'b0;
        end
        3: begin
          addr = $urandom_range(0, 32'h0FFF_FFFF);
          cap  = 1'b1;
        end
        4: addr = 32'h1000_0000 + $urandom_range(0, 64) - 32;
        default: begin
          // sector at a track edge within some cylinder, head random
          cyl  = $urandom_range(0, 70000);
          addr = cyl * CYL_SECTORS + $urandom_range(0, HEADS - 1) * SPT
                 + ($urandom_range(0, 1) ? SPT - 1 : 0);
          cap  = 1'b0;
        end
      endcase
      case ($urandom_range(0, 3))
        0: bytes = 17'($urandom_range(0, 131071));
        1: bytes = 17'($urandom_range(1, 255) * 512 - 1 + $urandom_range(0, 2));
        default: bytes = 17'($urandom_range(0, 4096));
      endcase
      send_request(addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cap,
                   bytes);

      // bursts of items separated by random gaps, often none
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Requests: %0d CHS, %0d LBA28, %0d LBA48 (%0d writes) in %0d cycles,",
             chs_sent, lba28_sent, lba48_sent, writes, cycle_count);
    $display("with bursty input, a long output hold-off and a mid-run drain.");
    if (fail_count == 0) begin
      $display("ata_task_file_builder_unit_tb: PASS");
    end else begin
      $display("ata_task_file_builder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/atfb_pkg.sv
design/atfb_cdiv.sv
design/atfb_fmt.sv
design/ata_task_file_builder_unit.sv
bench/atfb_task_file_checker.sv
bench/ata_task_file_builder_unit_tb.sv
